FILE: sv/lpl_pkg.sv
// Package for the lookahead peak limiter: payload structs, sequencer states
// and fixed constants. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package lpl_pkg;

  typedef struct packed {
    logic signed [23:0] sample_left;
    logic signed [23:0] sample_right;
    logic               block_last;
  } in_item_t;

  typedef struct packed {
    logic signed [23:0] out_left;
    logic signed [23:0] out_right;
    logic [16:0]        gain_now;
    logic               block_last_out;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_CLEAR, ST_ENV_A, ST_ENV_B, ST_DIV, ST_GAIN_A, ST_GAIN_B,
    ST_RING, ST_MUL_L, ST_MUL_R, ST_OUT
  } state_t;

  localparam logic [1:0] REG_THRESHOLD = 2'd0;
  localparam logic [1:0] REG_RELEASE   = 2'd1;
  localparam logic [1:0] REG_LENGTH    = 2'd2;
  localparam logic [1:0] REG_CHANNELS  = 2'd3;

  localparam logic [16:0] UNITY_GAIN = 17'd65536;
  localparam logic [23:0] FULL_SCALE = 24'd8388608;
  localparam logic [16:0] GAIN_KEEP  = 17'd65470;
  localparam logic [16:0] GAIN_TAKE  = 17'd66;
  localparam logic [4:0]  DIV_STEPS  = 5'd16;

endpackage
`default_nettype wire

FILE: sv/lookahead_peak_limiter_top.sv
// Lookahead peak limiter top level: sequencer around one shared 25x18 multiplier
// and a restoring divider; ring store as an in-module memory. Uses lpl_pkg.
// Each frame runs ENV_A, ENV_B, DIV (gain divider: one load and 16 one-bit
// steps), GAIN_A, GAIN_B, RING, MUL_L and MUL_R; one frame at a time, so a new
// frame is taken only after the result has been accepted by out_ready.
// Reset: synchronous; a clearing pass then zeroes all MAX_LOOKAHEAD ring entries
// before the first frame is taken. Config and control registers go to defaults.
`timescale 1ns / 1ps
`default_nettype none
module lookahead_peak_limiter_top #(
  parameter int MAX_LOOKAHEAD = 64
) (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  in_valid,
  output logic                 in_ready,
  input  lpl_pkg::in_item_t    in_data,
  output logic                 out_valid,
  input  wire                  out_ready,
  output lpl_pkg::out_item_t   out_data,
  input  wire                  cfg_we,
  input  wire [1:0]            cfg_index,
  input  wire [23:0]           cfg_data
);
  localparam int AW = (MAX_LOOKAHEAD > 1) ? $clog2(MAX_LOOKAHEAD) : 1;
  localparam int LW = $clog2(MAX_LOOKAHEAD + 1);

  logic [23:0] threshold_level;
  logic [15:0] release_coeff;
  logic [6:0]  lookahead_length;
  logic [1:0]  channel_count;

  lpl_pkg::state_t state, state_next;
  logic [23:0] envelope;
  logic [16:0] applied_gain;
  logic [AW-1:0] ring_pointer;
  logic [AW-1:0] clr_addr;
  logic signed [23:0] left, right;
  logic        last_r, stereo;
  logic [23:0] peak;
  logic [41:0] acc;
  logic [16:0] target;
  logic [39:0] div_rem;
  logic [16:0] quot;
  logic [4:0]  div_cnt;
  logic signed [23:0] dl, dr;
  logic [47:0] ring_mem [MAX_LOOKAHEAD];
  logic [47:0] rd_data;
  logic        ring_we;
  logic [AW-1:0] ring_waddr, rd_addr;
  logic [47:0] ring_wdata;

  // shared multiplier
  logic signed [24:0] mul_a;
  logic signed [17:0] mul_b;
  logic signed [42:0] mul_p;
  assign mul_p = mul_a * mul_b;

  // effective length
  logic [LW-1:0] len_eff;
  always_comb begin
    if (lookahead_length == 7'd0) len_eff = LW'(1);
    else if (32'(lookahead_length) > MAX_LOOKAHEAD) len_eff = LW'(MAX_LOOKAHEAD);
    else len_eff = LW'(lookahead_length);
  end

  logic [AW-1:0] wptr, nptr;
  always_comb begin
    wptr = (LW'(ring_pointer) >= len_eff) ? '0 : ring_pointer;
    nptr = (LW'(wptr) + LW'(1) >= len_eff) ? '0 : AW'(LW'(wptr) + LW'(1));
  end

  logic [23:0] mag_l, mag_r;
  assign mag_l = in_data.sample_left[23] ? 24'(-in_data.sample_left) : in_data.sample_left;
  assign mag_r = in_data.sample_right[23] ? 24'(-in_data.sample_right)
                                          : in_data.sample_right;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold_level <= 24'd7474250;
      release_coeff <= 16'd65470;
      lookahead_length <= 7'd48;
      channel_count <= 2'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        lpl_pkg::REG_THRESHOLD: threshold_level <= cfg_data;
        lpl_pkg::REG_RELEASE:   release_coeff <= cfg_data[15:0];
        lpl_pkg::REG_LENGTH:    lookahead_length <= cfg_data[6:0];
        lpl_pkg::REG_CHANNELS:  channel_count <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) state <= lpl_pkg::ST_CLEAR;
    else state <= state_next;
  end

  logic [40:0] div_trial;
  assign div_trial = {div_rem, 1'b0} - {17'd0, envelope};

  always_comb begin
    state_next = state;
    in_ready = 1'b0;
    mul_a = '0;
    mul_b = '0;
    case (state)
      lpl_pkg::ST_CLEAR:
        if (32'(clr_addr) == MAX_LOOKAHEAD - 1) state_next = lpl_pkg::ST_IDLE;
      lpl_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) state_next = lpl_pkg::ST_ENV_A;
      end
      lpl_pkg::ST_ENV_A: begin
        mul_a = 25'(envelope);
        mul_b = 18'(release_coeff);
        state_next = lpl_pkg::ST_ENV_B;
      end
      lpl_pkg::ST_ENV_B: begin
        mul_a = 25'(peak);
        mul_b = 18'(17'd65536 - 17'(release_coeff));
        state_next = lpl_pkg::ST_DIV;
      end
      lpl_pkg::ST_DIV:
        if (div_cnt == lpl_pkg::DIV_STEPS) state_next = lpl_pkg::ST_GAIN_A;
      lpl_pkg::ST_GAIN_A: begin
        mul_a = 25'(applied_gain);
        mul_b = 18'(lpl_pkg::GAIN_KEEP);
        state_next = lpl_pkg::ST_GAIN_B;
      end
      lpl_pkg::ST_GAIN_B: begin
        mul_a = 25'(target);
        mul_b = 18'(lpl_pkg::GAIN_TAKE);
        state_next = lpl_pkg::ST_RING;
      end
      lpl_pkg::ST_RING: state_next = lpl_pkg::ST_MUL_L;
      lpl_pkg::ST_MUL_L: begin
        mul_a = 25'(dl);
        mul_b = 18'(applied_gain);
        state_next = lpl_pkg::ST_MUL_R;
      end
      lpl_pkg::ST_MUL_R: begin
        mul_a = 25'(dr);
        mul_b = 18'(applied_gain);
        state_next = lpl_pkg::ST_OUT;
      end
      lpl_pkg::ST_OUT:
        if (out_ready) state_next = lpl_pkg::ST_IDLE;
      default: state_next = lpl_pkg::ST_IDLE;
    endcase
  end

  function automatic logic [23:0] sat_round(input logic signed [42:0] p);
    logic signed [42:0] r;
    r = (p + 43'sd32768) >>> 16;
    if (r > 43'sd8388607) return 24'h7FFFFF;
    if (r < -43'sd8388608) return 24'h800000;
    return r[23:0];
  endfunction

  always_comb begin
    ring_we = 1'b0;
    ring_waddr = wptr;
    ring_wdata = {left, right};
    rd_addr = nptr;
    if (state == lpl_pkg::ST_CLEAR) begin
      ring_we = 1'b1;
      ring_waddr = clr_addr;
      ring_wdata = '0;
    end else if (state == lpl_pkg::ST_GAIN_B) begin
      ring_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ring_we) ring_mem[ring_waddr] <= ring_wdata;
    rd_data <= ring_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      envelope <= lpl_pkg::FULL_SCALE;
      applied_gain <= lpl_pkg::UNITY_GAIN;
      ring_pointer <= '0;
      clr_addr <= '0;
      out_valid <= 1'b0;
    end else begin
      case (state)
        lpl_pkg::ST_CLEAR: clr_addr <= clr_addr + AW'(1);
        lpl_pkg::ST_IDLE:
          if (in_valid) begin
            stereo <= channel_count[1];
            left <= in_data.sample_left;
            right <= channel_count[1] ? in_data.sample_right : 24'sd0;
            last_r <= in_data.block_last;
            peak <= (channel_count[1] && mag_r > mag_l) ? mag_r : mag_l;
          end
        lpl_pkg::ST_ENV_A: acc <= 42'(mul_p);
        lpl_pkg::ST_ENV_B: begin
          if (peak > envelope) envelope <= peak;
          else envelope <= 24'((acc + 42'(mul_p)) >> 16);
          div_cnt <= '0;
          quot <= '0;
        end
        lpl_pkg::ST_DIV: begin
          if (div_cnt == 5'd0) begin
            div_rem <= {16'd0, threshold_level};
          end else begin
            if (!div_trial[40]) begin
              div_rem <= div_trial[39:0];
              quot <= {quot[15:0], 1'b1};
            end else begin
              div_rem <= {div_rem[38:0], 1'b0};
              quot <= {quot[15:0], 1'b0};
            end
          end
          if (div_cnt != lpl_pkg::DIV_STEPS) div_cnt <= div_cnt + 5'd1;
        end
        lpl_pkg::ST_GAIN_A: begin
          target <= (envelope > threshold_level) ? 17'(quot[15:0])
                                                 : lpl_pkg::UNITY_GAIN;
          acc <= 42'(mul_p);
        end
        lpl_pkg::ST_GAIN_B: begin
          if (target < applied_gain) applied_gain <= target;
          else applied_gain <= 17'((acc + 42'(mul_p) + 42'd65535) >> 16);
          ring_pointer <= nptr;
        end
        lpl_pkg::ST_RING: begin
          // one-frame ring: the frame read back is the one just written
          dl <= (len_eff == LW'(1)) ? left : rd_data[47:24];
          dr <= !stereo ? 24'sd0 : (len_eff == LW'(1)) ? right : rd_data[23:0];
        end
        lpl_pkg::ST_MUL_L: out_data.out_left <= sat_round(mul_p);
        lpl_pkg::ST_MUL_R: begin
          out_data.out_right <= sat_round(mul_p);
          out_data.gain_now <= applied_gain;
          out_data.block_last_out <= last_r;
          out_valid <= 1'b1;
        end
        lpl_pkg::ST_OUT: if (out_ready) out_valid <= 1'b0;
        default: ;
      endcase
    end
  end

`ifndef SYNTH
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !out_valid) else $error("ready while result pending");
  a_gain_range: assert property (@(posedge clk) disable iff (rst)
    applied_gain <= lpl_pkg::UNITY_GAIN) else $error("gain above unity");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result dropped");
  a_ptr_range: assert property (@(posedge clk) disable iff (rst)
    state == lpl_pkg::ST_RING |-> LW'(ring_pointer) < len_eff)
    else $error("pointer past length");
`endif

endmodule
`default_nettype wire
